>>> sv/fcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_pkg: shared constants for the framed command LED ramp
// Packet framing byte and command codes.
// ----------------------------------------------------------------------------
package fcl_pkg;

	localparam logic [7:0] FRAME_SYNC = 8'd255;
	localparam logic [7:0] CMD_STOP   = 8'd4;
	localparam logic [7:0] CMD_FALL   = 8'd2;
	localparam logic [7:0] CMD_RISE   = 8'd1;

	// Largest period that still counts ticks; larger values act as one.
	localparam logic [7:0] MAX_PERIOD = 8'd127;

	// Item kind carried by the cmd field
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [7:0] RESET_PERIOD = 8'd10;
	localparam logic [7:0] DUTY_STEP    = 8'd2;

endpackage

>>> sv/framed_command_led_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_led_ramp: packet parser and sawtooth duty generator
// Parses 255/command/data packets and steps a PWM duty on tick items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | cmd, rx_byte
//  out     | output    | out_valid/out_ready | duty, packet_done
//
//  One result per item, passed from the input register into the result
//  register; one item a cycle sustained while out_ready stays high, as the
//  parser and ramp state update once for each beat that moves on.
//  Reset puts the parser in the wait-for-start state, period 10, duty 0,
//  rising, ramp running, tick count 0.
//  A stalled result holds the input register; in_ready drops only while
//  both the input register and the result register are full and stalled.
// ----------------------------------------------------------------------------
module framed_command_led_ramp #(
	parameter int FULL_DUTY = 100
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] duty,
	output logic       packet_done
);

	localparam logic [7:0] FULL = 8'(FULL_DUTY);

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_COMMAND = 2'd1,
		PH_DATA    = 2'd2
	} phase_t;

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// state
	phase_t     phase_q;
	logic [7:0] held_cmd_q;
	logic [7:0] period_q;
	logic [7:0] duty_q;
	logic       falling_q;
	logic       running_q;
	logic [7:0] tick_q;

	// result register
	logic       out_valid_q;
	logic       done_q;

	logic       out_load;
	logic       advance;

	phase_t     phase_d;
	logic [7:0] held_cmd_d;
	logic [7:0] period_d;
	logic [7:0] duty_d;
	logic       falling_d;
	logic       running_d;
	logic [7:0] tick_d;
	logic       done_d;

	logic [7:0] eff_period;
	logic [7:0] tick_inc;
	logic [7:0] duty_base;

	assign out_load = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_load;
	assign in_ready = !valid_s1 || out_load;

	assign out_valid   = out_valid_q;
	assign duty        = duty_q[6:0];
	assign packet_done = done_q;

	always_comb begin
		phase_d    = phase_q;
		held_cmd_d = held_cmd_q;
		period_d   = period_q;
		duty_d     = duty_q;
		falling_d  = falling_q;
		running_d  = running_q;
		tick_d     = tick_q;
		done_d     = 1'b0;
		duty_base  = duty_q;

		eff_period = (period_q == 8'd0 || period_q > fcl_pkg::MAX_PERIOD) ? 8'd1 : period_q;
		tick_inc   = tick_q + 8'd1;

		if (cmd_s1 == fcl_pkg::KIND_TICK) begin
			tick_d = tick_inc;
			if (tick_inc >= eff_period) begin
				tick_d = 8'd0;
				if (running_q) begin
					if (falling_q) begin
						// wrap below the step back to full duty
						if (duty_q < fcl_pkg::DUTY_STEP)
							duty_base = FULL;
						duty_d = duty_base - fcl_pkg::DUTY_STEP;
					end else begin
						if (duty_q >= FULL)
							duty_base = 8'd0;
						duty_d = duty_base + fcl_pkg::DUTY_STEP;
					end
				end
			end
		end else if (byte_s1 == fcl_pkg::FRAME_SYNC) begin
			phase_d = PH_COMMAND;
		end else begin
			case (phase_q)
				PH_COMMAND: begin
					held_cmd_d = byte_s1;
					phase_d    = PH_DATA;
				end
				PH_DATA: begin
					done_d    = 1'b1;
					phase_d   = PH_WAIT;
					period_d  = byte_s1;
					running_d = 1'b1;
					if (held_cmd_q == fcl_pkg::CMD_STOP) begin
						running_d = 1'b0;
						duty_d    = 8'd0;
					end else if (held_cmd_q == fcl_pkg::CMD_FALL) begin
						falling_d = 1'b1;
						duty_d    = FULL;
					end else if (held_cmd_q == fcl_pkg::CMD_RISE) begin
						falling_d = 1'b0;
						duty_d    = 8'd0;
					end
				end
				default: begin
					// stray byte, or the unused phase: drop it
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_WAIT;
			held_cmd_q  <= 8'd0;
			period_q    <= fcl_pkg::RESET_PERIOD;
			duty_q      <= 8'd0;
			falling_q   <= 1'b0;
			running_q   <= 1'b1;
			tick_q      <= 8'd0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (out_load)
				out_valid_q <= valid_s1;
			if (advance) begin
				phase_q    <= phase_d;
				held_cmd_q <= held_cmd_d;
				period_q   <= period_d;
				duty_q     <= duty_d;
				falling_q  <= falling_d;
				running_q  <= running_d;
				tick_q     <= tick_d;
				done_q     <= done_d;
			end
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			byte_s1 <= rx_byte;
		end
	end

`ifndef ASSERT_OFF
	// a finished packet leaves the parser waiting for the next start byte
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> phase_q == PH_WAIT)
		else $error("packet_done shown while parser is not waiting");

	// hold all state while the beat in the input register is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(duty_q) && $stable(tick_q) && $stable(phase_q))
		else $error("state changed without a beat");

	// the ramp never climbs more than one past full duty
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, duty_q} <= ({1'b0, FULL} + 9'd1))
		else $error("duty out of range");
`endif

endmodule
